// ===== src/rmq_pkg.sv =====
package rmq_pkg;

   localparam int DATA_WIDTH = 16;
   localparam int FRAC_BITS_DEFAULT = 14;
   localparam int NORM_WIDTH = 31;
   localparam int NORM2_WIDTH = 64;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] r00;
      logic signed [DATA_WIDTH-1:0] r01;
      logic signed [DATA_WIDTH-1:0] r02;
      logic signed [DATA_WIDTH-1:0] r10;
      logic signed [DATA_WIDTH-1:0] r11;
      logic signed [DATA_WIDTH-1:0] r12;
      logic signed [DATA_WIDTH-1:0] r20;
      logic signed [DATA_WIDTH-1:0] r21;
      logic signed [DATA_WIDTH-1:0] r22;
   } req_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] quat_x;
      logic signed [DATA_WIDTH-1:0] quat_y;
      logic signed [DATA_WIDTH-1:0] quat_z;
      logic signed [DATA_WIDTH-1:0] quat_w;
      logic                         invalid;
   } rsp_type;

endpackage

// ===== src/rmq_isqrt.sv =====
module rmq_isqrt #(
   parameter int IN_W = rmq_pkg::NORM2_WIDTH
) (
   input  logic              clock,
   input  logic              enable,
   input  logic [IN_W-1:0]   radicand,
   output logic [IN_W/2-1:0] root
);
   import rmq_pkg::*;

   localparam int RW = IN_W / 2;
   localparam int REMW = RW + 2;

   logic [REMW-1:0] rem_ff [RW];
   logic [RW-1:0]   root_ff [RW];
   logic [IN_W-1:0] rad_ff [RW];

   for (genvar j = 0; j < RW; j++) begin : g_step
      logic [REMW-1:0] rem_src;
      logic [RW-1:0]   root_src;
      logic [IN_W-1:0] rad_src;
      logic [REMW+1:0] remx;
      logic [REMW+1:0] trial;
      logic [REMW-1:0] rem_in;
      logic [RW-1:0]   root_in;

      if (j == 0) begin : g_first
         assign rem_src  = '0;
         assign root_src = '0;
         assign rad_src  = radicand;
      end else begin : g_next
         assign rem_src  = rem_ff[j-1];
         assign root_src = root_ff[j-1];
         assign rad_src  = rad_ff[j-1];
      end

      always_comb begin
         remx  = {rem_src, rad_src[IN_W-1:IN_W-2]};
         trial = {{(REMW-RW){1'b0}}, root_src, 2'b01};
         if (remx >= trial) begin
            rem_in  = REMW'(remx - trial);
            root_in = {root_src[RW-2:0], 1'b1};
         end else begin
            rem_in  = REMW'(remx);
            root_in = {root_src[RW-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[j]  <= rem_in;
            root_ff[j] <= root_in;
            rad_ff[j]  <= {rad_src[IN_W-3:0], 2'b00};
         end
      end
   end

   assign root = root_ff[RW-1];

endmodule

// ===== src/rotation_matrix_to_quaternion_unit.sv =====
// Rotation matrix to unit quaternion, Shepperd's method, fixed point.
// Input channel req_*: one 3x3 row-major matrix per transaction, signed
// Q.FRAC_BITS entries. Result channel rsp_*: one quaternion (x, y, z, w)
// per transaction in the same format, plus an invalid flag that is set,
// with all components zero, when the chosen branch radicand is not
// positive.
// The pipeline is six stages of branch select, magnitude, leading-one,
// shift, square and sum, 32 stages of the restoring square root,
// FRAC_BITS + 2 stages of the four-lane restoring divider, and the
// rounding output register.
// Throughput is one transaction per cycle while rsp_stall does not hold
// the pipeline; new matrices enter with earlier ones in flight.
// Reset clears every stage valid bit; the pipeline comes up empty.
// A stall on rsp_stall while a result is held freezes the whole pipeline
// and raises req_stall in the same cycle; nothing is lost or repeated.
module rotation_matrix_to_quaternion_unit #(
   parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  rmq_pkg::req_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rmq_pkg::rsp_type rsp_data
);
   import rmq_pkg::*;

   localparam int DW = DATA_WIDTH;
   localparam int IW = ((DW > FRAC_BITS + 1) ? DW : FRAC_BITS + 1) + 3;
   localparam int PW = $clog2(IW);
   localparam int NW = NORM_WIDTH;
   localparam int SQW = 2 * NW;
   localparam int N2W = NORM2_WIDTH;
   localparam int RW = N2W / 2;
   localparam int QW = FRAC_BITS + 2;
   localparam int DRW = RW + 1;
   localparam int LW = (QW > DW) ? QW : DW;
   localparam logic signed [IW-1:0] ONE_V = {{(IW-1){1'b0}}, 1'b1} << FRAC_BITS;
   localparam logic [LW-1:0] LIM = {{(LW-DW+1){1'b0}}, {(DW-1){1'b1}}};

   logic en;
   assign en = !(rsp_valid && rsp_stall);
   assign req_stall = !en;

   // branch select
   logic signed [IW-1:0] a00, a01, a02, a10, a11, a12, a20, a21, a22, tr, rad;
   logic signed [IW-1:0] v_in [4];
   logic signed [IW-1:0] v1_ff [4];
   logic inv1_ff, vld1_ff;

   always_comb begin
      a00 = IW'(req_data.r00);
      a01 = IW'(req_data.r01);
      a02 = IW'(req_data.r02);
      a10 = IW'(req_data.r10);
      a11 = IW'(req_data.r11);
      a12 = IW'(req_data.r12);
      a20 = IW'(req_data.r20);
      a21 = IW'(req_data.r21);
      a22 = IW'(req_data.r22);
      tr  = a00 + a11 + a22;
      priority if (tr > 0) begin
         rad = tr + ONE_V;
         v_in[3] = rad; v_in[0] = a12 - a21; v_in[1] = a20 - a02; v_in[2] = a01 - a10;
      end else if (a00 > a11 && a00 > a22) begin
         rad = ONE_V + a00 - a11 - a22;
         v_in[3] = a12 - a21; v_in[0] = rad; v_in[1] = a01 + a10; v_in[2] = a20 + a02;
      end else if (a11 > a22) begin
         rad = ONE_V + a11 - a00 - a22;
         v_in[3] = a20 - a02; v_in[0] = a01 + a10; v_in[1] = rad; v_in[2] = a12 + a21;
      end else begin
         rad = ONE_V + a22 - a00 - a11;
         v_in[3] = a01 - a10; v_in[0] = a20 + a02; v_in[1] = a12 + a21; v_in[2] = rad;
      end
   end

   // magnitude and maximum
   logic [IW-1:0] mag_in [4];
   logic [IW-1:0] m01, m23, mx_in;
   logic [IW-1:0] mag2_ff [4];
   logic [IW-1:0] mx2_ff;
   logic [3:0] neg2_ff;
   logic inv2_ff, vld2_ff;

   always_comb begin
      for (int l = 0; l < 4; l++) begin
         mag_in[l] = v1_ff[l][IW-1] ? IW'(-v1_ff[l]) : IW'(v1_ff[l]);
      end
      m01   = (mag_in[0] > mag_in[1]) ? mag_in[0] : mag_in[1];
      m23   = (mag_in[2] > mag_in[3]) ? mag_in[2] : mag_in[3];
      mx_in = (m01 > m23) ? m01 : m23;
   end

   // leading one
   logic [PW-1:0] p_in;
   logic [PW-1:0] p3_ff;
   logic [IW-1:0] mag3_ff [4];
   logic [3:0] neg3_ff;
   logic inv3_ff, vld3_ff;

   always_comb begin
      p_in = '0;
      for (int i = 0; i < IW; i++) begin
         if (mx2_ff[i]) p_in = PW'(i);
      end
   end

   // shift to common scale
   logic [IW+NW-2:0] wide [4];
   logic [NW-1:0] norm_in [4];
   logic [NW-1:0] norm4_ff [4];
   logic [3:0] neg4_ff;
   logic inv4_ff, vld4_ff;

   always_comb begin
      for (int l = 0; l < 4; l++) begin
         wide[l]    = {mag3_ff[l], {(NW-1){1'b0}}} >> p3_ff;
         norm_in[l] = wide[l][NW-1:0];
      end
   end

   // squares and sum
   logic [SQW-1:0] sq5_ff [4];
   logic [NW-1:0] norm5_ff [4];
   logic [3:0] neg5_ff;
   logic inv5_ff, vld5_ff;
   logic [N2W-1:0] n2_6_ff;
   logic [NW-1:0] norm6_ff [4];
   logic [3:0] neg6_ff;
   logic inv6_ff, vld6_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         v1_ff   <= v_in;
         inv1_ff <= (rad <= 0);
         mag2_ff <= mag_in;
         mx2_ff  <= mx_in;
         for (int l = 0; l < 4; l++) neg2_ff[l] <= v1_ff[l][IW-1];
         inv2_ff <= inv1_ff;
         p3_ff   <= p_in;
         mag3_ff <= mag2_ff;
         neg3_ff <= neg2_ff;
         inv3_ff <= inv2_ff;
         norm4_ff <= norm_in;
         neg4_ff  <= neg3_ff;
         inv4_ff  <= inv3_ff;
         for (int l = 0; l < 4; l++) sq5_ff[l] <= norm4_ff[l] * norm4_ff[l];
         norm5_ff <= norm4_ff;
         neg5_ff  <= neg4_ff;
         inv5_ff  <= inv4_ff;
         n2_6_ff  <= N2W'(sq5_ff[0]) + N2W'(sq5_ff[1]) + N2W'(sq5_ff[2])
                   + N2W'(sq5_ff[3]);
         norm6_ff <= norm5_ff;
         neg6_ff  <= neg5_ff;
         inv6_ff  <= inv5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
         vld4_ff <= 1'b0;
         vld5_ff <= 1'b0;
         vld6_ff <= 1'b0;
      end else if (en) begin
         vld1_ff <= req_valid;
         vld2_ff <= vld1_ff;
         vld3_ff <= vld2_ff;
         vld4_ff <= vld3_ff;
         vld5_ff <= vld4_ff;
         vld6_ff <= vld5_ff;
      end
   end

   // square root with side band alongside
   logic [RW-1:0] root;

   rmq_isqrt #(
      .IN_W(N2W)
   ) u_isqrt (
      .clock(clock),
      .enable(en),
      .radicand(n2_6_ff),
      .root(root)
   );

   logic [NW-1:0] sd_norm_ff [RW][4];
   logic [3:0] sd_neg_ff [RW];
   logic sd_inv_ff [RW];
   logic sd_vld_ff [RW];

   always_ff @(posedge clock) begin
      if (en) begin
         sd_norm_ff[0] <= norm6_ff;
         sd_neg_ff[0]  <= neg6_ff;
         sd_inv_ff[0]  <= inv6_ff;
         for (int j = 1; j < RW; j++) begin
            sd_norm_ff[j] <= sd_norm_ff[j-1];
            sd_neg_ff[j]  <= sd_neg_ff[j-1];
            sd_inv_ff[j]  <= sd_inv_ff[j-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < RW; j++) sd_vld_ff[j] <= 1'b0;
      end else if (en) begin
         sd_vld_ff[0] <= vld6_ff;
         for (int j = 1; j < RW; j++) sd_vld_ff[j] <= sd_vld_ff[j-1];
      end
   end

   // restoring division, one quotient bit per stage for all four lanes
   logic [QW-1:0] dq_ff [QW][4];
   logic [DRW-1:0] drem_ff [QW][4];
   logic [RW-1:0] dnrm_ff [QW];
   logic [3:0] dneg_ff [QW];
   logic dinv_ff [QW];
   logic dvld_ff [QW];

   for (genvar s = 0; s < QW; s++) begin : g_div
      logic [DRW-1:0] cand [4];
      logic [QW-1:0] qp [4];
      logic [RW-1:0] nrm_src;
      logic [3:0] neg_src;
      logic inv_src, vld_src;
      logic [DRW-1:0] rem_in [4];
      logic [QW-1:0] q_in [4];

      if (s == 0) begin : g_first
         always_comb begin
            for (int l = 0; l < 4; l++) begin
               cand[l] = {{(DRW-NW){1'b0}}, sd_norm_ff[RW-1][l]};
               qp[l]   = '0;
            end
         end
         assign nrm_src = root;
         assign neg_src = sd_neg_ff[RW-1];
         assign inv_src = sd_inv_ff[RW-1];
         assign vld_src = sd_vld_ff[RW-1];
      end else begin : g_next
         always_comb begin
            for (int l = 0; l < 4; l++) begin
               cand[l] = {drem_ff[s-1][l][DRW-2:0], 1'b0};
               qp[l]   = dq_ff[s-1][l];
            end
         end
         assign nrm_src = dnrm_ff[s-1];
         assign neg_src = dneg_ff[s-1];
         assign inv_src = dinv_ff[s-1];
         assign vld_src = dvld_ff[s-1];
      end

      always_comb begin
         for (int l = 0; l < 4; l++) begin
            if (cand[l] >= {1'b0, nrm_src}) begin
               rem_in[l] = cand[l] - {1'b0, nrm_src};
               q_in[l]   = {qp[l][QW-2:0], 1'b1};
            end else begin
               rem_in[l] = cand[l];
               q_in[l]   = {qp[l][QW-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            dq_ff[s]   <= q_in;
            drem_ff[s] <= rem_in;
            dnrm_ff[s] <= nrm_src;
            dneg_ff[s] <= neg_src;
            dinv_ff[s] <= inv_src;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dvld_ff[s] <= 1'b0;
         end else if (en) begin
            dvld_ff[s] <= vld_src;
         end
      end
   end

   // round, saturate, sign
   logic [QW:0] rnd [4];
   logic [LW-1:0] sat [4];
   logic [DW-1:0] om [4];
   logic [DW-1:0] oq [4];
   rsp_type rsp_in;
   rsp_type rsp_data_ff;
   logic rsp_valid_ff;

   always_comb begin
      for (int l = 0; l < 4; l++) begin
         rnd[l] = ({1'b0, dq_ff[QW-1][l]} + 1'b1) >> 1;
         sat[l] = (LW'(rnd[l]) > LIM) ? LIM : LW'(rnd[l]);
         om[l]  = sat[l][DW-1:0];
         oq[l]  = dinv_ff[QW-1] ? '0 : (dneg_ff[QW-1][l] ? DW'(-om[l]) : om[l]);
      end
      rsp_in.quat_x  = signed'(oq[0]);
      rsp_in.quat_y  = signed'(oq[1]);
      rsp_in.quat_z  = signed'(oq[2]);
      rsp_in.quat_w  = signed'(oq[3]);
      rsp_in.invalid = dinv_ff[QW-1];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= dvld_ff[QW-1];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.invalid |-> rsp_data.quat_x == 0 && rsp_data.quat_y == 0
         && rsp_data.quat_z == 0 && rsp_data.quat_w == 0)
      else $error("invalid result carries a nonzero component");

   a_valid_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.invalid |-> rsp_data.quat_x != 0 || rsp_data.quat_y != 0
         || rsp_data.quat_z != 0 || rsp_data.quat_w != 0)
      else $error("valid result is the zero quaternion");

   a_stall_freeze: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(n2_6_ff) && $stable(dvld_ff[0]))
      else $error("pipeline advanced under output stall");

endmodule
